@@ rtl/nearest_landmark_ahead_select_assert.svh @@
// Assertion macros shared by the landmark selector modules.
`ifndef NEAREST_LANDMARK_AHEAD_SELECT_ASSERT_SVH
`define NEAREST_LANDMARK_AHEAD_SELECT_ASSERT_SVH
`ifndef SYNTHESIS
`define NLAS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define NLAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NLAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NLAS_ASSERT(label, clk, rst_n, prop, msg)
`define NLAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define NLAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/nlas_pkg.sv @@
`timescale 1ns / 1ps
package nlas_pkg;

    localparam int COORD_W = 35;
    localparam int ANGLE_W = 16;
    localparam int TRIG_W  = 16;
    localparam int DIST_W  = 20;
    localparam int TYPE_W  = 8;
    localparam int DSQ_W   = 40;
    localparam int DELTA_W = 21;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int DOT_W   = DELTA_W + TRIG_W + 1;
    localparam int IDX_W   = 3;

    localparam logic [DSQ_W-1:0] NONE_DIST_SQ = 40'd999800010000;
    localparam logic [DSQ_W-1:0] MAX_SQ_RESET = 40'd100000000;

    // 10 degrees expressed in 2^-13 rad, truncated.
    localparam logic signed [ANGLE_W:0] HEADING_LIMIT = 17'sd1429;

    // Offsets of 2^20 or more are rejected outright.
    localparam logic signed [DIFF_W-1:0] DELTA_MAX = 36'sd1048575;
    localparam logic signed [DIFF_W-1:0] DELTA_MIN = -36'sd1048575;

    localparam logic KIND_ANNOT = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_CAR_X        = 3'd0,
        REG_CAR_Y        = 3'd1,
        REG_CAR_HEADING  = 3'd2,
        REG_HEADING_COS  = 3'd3,
        REG_HEADING_SIN  = 3'd4,
        REG_MAX_DISTANCE = 3'd5,
        REG_WANTED_TYPE  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] car_x;
        logic [COORD_W-1:0] car_y;
        logic [ANGLE_W-1:0] car_heading;
        logic [TRIG_W-1:0]  heading_cos;
        logic [TRIG_W-1:0]  heading_sin;
        logic [DSQ_W-1:0]   max_sq;
        logic [TYPE_W-1:0]  wanted_type;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [TYPE_W-1:0]  ann_code;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [COORD_W-1:0] point_z;
        logic [ANGLE_W-1:0] facing;
    } item_t;

    // Classified item passed from the front pipeline to the search unit.
    typedef struct packed {
        logic               kind;
        logic               cand;
        logic [DSQ_W-1:0]   dist_sq;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [COORD_W-1:0] point_z;
    } entry_t;

endpackage

@@ rtl/nlas_front.sv @@
`timescale 1ns / 1ps
module nlas_front
    import nlas_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  item_t      in_item,
    input  cfg_t       cfg,
    output logic       push,
    output entry_t     push_entry,
    output logic [1:0] inflight
);

    // Stage 1: offsets and the cheap tests.
    logic [DIFF_W-1:0]  dx_full;
    logic [DIFF_W-1:0]  dy_full;
    logic [ANGLE_W:0]   head_diff;
    logic               range_ok;
    logic               head_ok;
    logic               type_ok;

    logic               v1_reg;
    logic               kind1_reg;
    logic               pass1_reg;
    logic [DELTA_W-1:0] dx1_reg;
    logic [DELTA_W-1:0] dy1_reg;
    logic [COORD_W-1:0] x1_reg, y1_reg, z1_reg;

    // Stage 2: products.
    logic signed [2*DELTA_W-1:0]      sqx_full, sqy_full;
    logic signed [DELTA_W+TRIG_W-1:0] dotx_full, doty_full;

    logic                             v2_reg;
    logic                             kind2_reg;
    logic                             pass2_reg;
    logic [DSQ_W-1:0]                 sqx2_reg, sqy2_reg;
    logic [DELTA_W+TRIG_W-1:0]        dotx2_reg, doty2_reg;
    logic [COORD_W-1:0]               x2_reg, y2_reg, z2_reg;

    // Stage 3: sums and final tests.
    logic [DSQ_W:0]   d2_sum;
    logic [DOT_W-1:0] dot_sum;
    logic             cand3;

    logic             push_reg;
    entry_t           entry_reg;

    assign dx_full   = {in_item.point_x[COORD_W-1], in_item.point_x}
                     - {cfg.car_x[COORD_W-1], cfg.car_x};
    assign dy_full   = {in_item.point_y[COORD_W-1], in_item.point_y}
                     - {cfg.car_y[COORD_W-1], cfg.car_y};
    assign head_diff = {cfg.car_heading[ANGLE_W-1], cfg.car_heading}
                     - {in_item.facing[ANGLE_W-1], in_item.facing};

    assign range_ok = ($signed(dx_full) <= DELTA_MAX) && ($signed(dx_full) >= DELTA_MIN)
                   && ($signed(dy_full) <= DELTA_MAX) && ($signed(dy_full) >= DELTA_MIN);
    assign head_ok  = ($signed(head_diff) <= HEADING_LIMIT)
                   && ($signed(head_diff) >= -HEADING_LIMIT);
    assign type_ok  = (in_item.ann_code == cfg.wanted_type);

    assign sqx_full  = $signed(dx1_reg) * $signed(dx1_reg);
    assign sqy_full  = $signed(dy1_reg) * $signed(dy1_reg);
    assign dotx_full = $signed(dx1_reg) * $signed(cfg.heading_cos);
    assign doty_full = $signed(dy1_reg) * $signed(cfg.heading_sin);

    assign d2_sum  = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
    assign dot_sum = {dotx2_reg[DELTA_W+TRIG_W-1], dotx2_reg}
                   + {doty2_reg[DELTA_W+TRIG_W-1], doty2_reg};
    assign cand3   = pass2_reg && (d2_sum <= {1'b0, cfg.max_sq}) && !dot_sum[DOT_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            push_reg <= 1'b0;
        end else begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            push_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        kind1_reg <= in_item.kind;
        pass1_reg <= (in_item.kind == KIND_ANNOT) && type_ok && range_ok && head_ok;
        dx1_reg   <= dx_full[DELTA_W-1:0];
        dy1_reg   <= dy_full[DELTA_W-1:0];
        x1_reg    <= in_item.point_x;
        y1_reg    <= in_item.point_y;
        z1_reg    <= in_item.point_z;

        kind2_reg <= kind1_reg;
        pass2_reg <= pass1_reg;
        sqx2_reg  <= DSQ_W'(unsigned'(sqx_full));
        sqy2_reg  <= DSQ_W'(unsigned'(sqy_full));
        dotx2_reg <= dotx_full;
        doty2_reg <= doty_full;
        x2_reg    <= x1_reg;
        y2_reg    <= y1_reg;
        z2_reg    <= z1_reg;

        entry_reg.kind    <= kind2_reg;
        entry_reg.cand    <= cand3;
        entry_reg.dist_sq <= d2_sum[DSQ_W-1:0];
        entry_reg.point_x <= x2_reg;
        entry_reg.point_y <= y2_reg;
        entry_reg.point_z <= z2_reg;
    end

    assign push       = push_reg;
    assign push_entry = entry_reg;
    assign inflight   = {1'b0, v1_reg} + {1'b0, v2_reg} + {1'b0, push_reg};

endmodule

@@ rtl/nlas_queue.sv @@
`timescale 1ns / 1ps
`include "nearest_landmark_ahead_select_assert.svh"
module nlas_queue
    import nlas_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  entry_t                     push_entry,
    input  logic                       pop,
    output logic                       head_valid,
    output entry_t                     head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    entry_t           slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];
    assign count      = count_reg;

    `NLAS_ASSERT(a_no_overflow, aclk, aresetn, !(push && count_reg == CNT_W'(DEPTH)), "queue push while full")
    `NLAS_ASSERT(a_no_underflow, aclk, aresetn, !(pop && count_reg == '0), "queue pop while empty")
    `NLAS_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == CNT_W'($past(count_reg) + 1'b1), "queue count lost a push")

endmodule

@@ rtl/nlas_back.sv @@
`timescale 1ns / 1ps
`include "nearest_landmark_ahead_select_assert.svh"
module nlas_back
    import nlas_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  entry_t             head,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               out_found,
    output logic [DSQ_W-1:0]   out_dist_sq,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic [COORD_W-1:0] out_z
);

    logic [DSQ_W-1:0]   best_reg;
    logic [COORD_W-1:0] held_x_reg, held_y_reg, held_z_reg;
    logic               out_valid_reg, out_valid_next;
    logic               found_reg;
    logic [DSQ_W-1:0]   dist_reg;
    logic [COORD_W-1:0] ox_reg, oy_reg, oz_reg;
    logic               take_end;
    logic               take_best;

    // An annotation never waits on the output; an end item needs a free result slot.
    assign pop       = head_valid && ((head.kind == KIND_ANNOT) || !out_valid_reg || m_tready);
    assign take_end  = pop && (head.kind == KIND_END);
    assign take_best = pop && (head.kind == KIND_ANNOT) && head.cand
                    && (head.dist_sq < best_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take_end) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg      <= NONE_DIST_SQ;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            held_z_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take_end) begin
                best_reg <= NONE_DIST_SQ;
            end else if (take_best) begin
                best_reg   <= head.dist_sq;
                held_x_reg <= head.point_x;
                held_y_reg <= head.point_y;
                held_z_reg <= head.point_z;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_end) begin
            found_reg <= (best_reg != NONE_DIST_SQ);
            dist_reg  <= best_reg;
            ox_reg    <= held_x_reg;
            oy_reg    <= held_y_reg;
            oz_reg    <= held_z_reg;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign out_found   = found_reg;
    assign out_dist_sq = dist_reg;
    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_z       = oz_reg;

    `NLAS_ASSERT_IMP(a_found_match, aclk, aresetn, out_valid_reg, found_reg == (dist_reg != NONE_DIST_SQ), "found flag disagrees with distance")
    `NLAS_ASSERT_NEXT(a_best_reload, aclk, aresetn, take_end, best_reg == NONE_DIST_SQ, "best distance not reloaded after end item")
    `NLAS_ASSERT(a_best_bound, aclk, aresetn, best_reg <= NONE_DIST_SQ, "best distance above the none value")

endmodule

@@ rtl/nearest_landmark_ahead_select.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       tdata annotation, tuser kind
// m_        out        m_tvalid / m_tready       tdata nearest landmark, tuser found
// cfg_      in         cfg_valid / cfg_ready     cfg_index register, cfg_data value
//
// One item is accepted per cycle while s_tready is high. The search unit retires one queued
// item per cycle, but an end item leaves the queue only while the output is free, and its
// result is registered as it leaves. Reset is synchronous on aresetn low and restores the
// control, configuration and search registers, but not the datapath and payload registers.
// While m_tready is low the result holds and annotations keep draining; s_tready falls
// once the queue plus the front pipeline hold QUEUE_DEPTH items (5 or more sustains 1/cycle).
module nearest_landmark_ahead_select
    import nlas_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // ann_code[7:0], point_x[42:8], point_y[77:43], point_z[112:78],
    // facing[128:113], zero fill above
    input  logic [135:0]       s_tdata,
    // kind[0]
    input  logic               s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // nearest_dist_sq[39:0], nearest_x[74:40], nearest_y[109:75], nearest_z[144:110],
    // zero fill above
    output logic [151:0]       m_tdata,
    // found[0]
    output logic               m_tuser,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [COORD_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [COORD_W-1:0] car_x_reg, car_y_reg;
    logic [ANGLE_W-1:0] car_heading_reg;
    logic [TRIG_W-1:0]  heading_cos_reg, heading_sin_reg;
    logic [DSQ_W-1:0]   max_sq_reg;
    logic [TYPE_W-1:0]  wanted_type_reg;

    cfg_t               cfg;
    item_t              in_item;
    logic               in_accept;
    logic               push;
    entry_t             push_entry;
    logic [1:0]         inflight;
    logic               pop;
    logic               head_valid;
    entry_t             head;
    logic [CNT_W-1:0]   count;
    logic [CNT_W:0]     occupancy;
    logic               out_found;
    logic [DSQ_W-1:0]   out_dist_sq;
    logic [COORD_W-1:0] out_x, out_y, out_z;

    assign cfg_ready = 1'b1;

    // The limit is kept squared, so distances compare without a root.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_x_reg       <= '0;
            car_y_reg       <= '0;
            car_heading_reg <= '0;
            heading_cos_reg <= 16'sd16384;
            heading_sin_reg <= '0;
            max_sq_reg      <= MAX_SQ_RESET;
            wanted_type_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CAR_X:        car_x_reg       <= cfg_data;
                REG_CAR_Y:        car_y_reg       <= cfg_data;
                REG_CAR_HEADING:  car_heading_reg <= cfg_data[ANGLE_W-1:0];
                REG_HEADING_COS:  heading_cos_reg <= cfg_data[TRIG_W-1:0];
                REG_HEADING_SIN:  heading_sin_reg <= cfg_data[TRIG_W-1:0];
                REG_MAX_DISTANCE: max_sq_reg      <= {{(DSQ_W-DIST_W){1'b0}}, cfg_data[DIST_W-1:0]}
                                                   * {{(DSQ_W-DIST_W){1'b0}}, cfg_data[DIST_W-1:0]};
                REG_WANTED_TYPE:  wanted_type_reg <= cfg_data[TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.car_x       = car_x_reg;
    assign cfg.car_y       = car_y_reg;
    assign cfg.car_heading = car_heading_reg;
    assign cfg.heading_cos = heading_cos_reg;
    assign cfg.heading_sin = heading_sin_reg;
    assign cfg.max_sq      = max_sq_reg;
    assign cfg.wanted_type = wanted_type_reg;

    assign in_item.kind     = s_tuser;
    assign in_item.ann_code = s_tdata[7:0];
    assign in_item.point_x  = s_tdata[42:8];
    assign in_item.point_y  = s_tdata[77:43];
    assign in_item.point_z  = s_tdata[112:78];
    assign in_item.facing   = s_tdata[128:113];

    // Every item in the front pipeline already holds a queue slot.
    assign occupancy = {1'b0, count} + (CNT_W+1)'(inflight);
    assign s_tready  = (occupancy < (CNT_W+1)'(QUEUE_DEPTH));
    assign in_accept = s_tvalid && s_tready;

    nlas_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_accept),
        .in_item    (in_item),
        .cfg        (cfg),
        .push       (push),
        .push_entry (push_entry),
        .inflight   (inflight)
    );

    nlas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (count)
    );

    nlas_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_found   (out_found),
        .out_dist_sq (out_dist_sq),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z)
    );

    assign m_tdata = {7'd0, out_z, out_y, out_x, out_dist_sq};
    assign m_tuser = out_found;

endmodule

@@ dv/nearest_landmark_ahead_select_checker.sv @@
`timescale 1ns / 1ps
module nearest_landmark_ahead_select_checker
    import nlas_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [135:0]       s_tdata,
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [151:0]       m_tdata,
    input  logic               m_tuser,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [COORD_W-1:0] cfg_data,
    output int                 owed,
    output int                 errors
);

    localparam longint NO_LANDMARK_SQ = 64'd999800010000;
    localparam longint FAR_OFFSET     = 64'd1048576;
    localparam longint HEADING_SPAN   = 64'd1429;
    localparam int     REPORT_LIMIT   = 10;

    typedef struct packed {
        logic               found;
        logic [DSQ_W-1:0]   dist_sq;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } landmark_report_t;

    // Pose and search settings as last written over the register channel.
    longint pose_x, pose_y, pose_heading, pose_cos, pose_sin, reach;
    logic [TYPE_W-1:0] target_type;

    // Running search state.
    longint best_sq;
    logic [COORD_W-1:0] held_x, held_y, held_z;

    landmark_report_t report_q[$];
    int miss_count = 0;

    assign errors = miss_count;

    function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                           input logic [COORD_W-1:0] data);
        logic signed [COORD_W-1:0] wide;
        logic signed [ANGLE_W-1:0] narrow;
        wide = data;
        narrow = data[ANGLE_W-1:0];
        case (cfg_reg_t'(idx))
            REG_CAR_X:        pose_x = longint'(wide);
            REG_CAR_Y:        pose_y = longint'(wide);
            REG_CAR_HEADING:  pose_heading = longint'(narrow);
            REG_HEADING_COS:  pose_cos = longint'(narrow);
            REG_HEADING_SIN:  pose_sin = longint'(narrow);
            REG_MAX_DISTANCE: reach = longint'(data[DIST_W-1:0]);
            REG_WANTED_TYPE:  target_type = data[TYPE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void search_step(input logic kind, input logic [135:0] data);
        logic signed [COORD_W-1:0] raw_x, raw_y;
        logic signed [ANGLE_W-1:0] raw_facing;
        longint dx, dy, d2, turn, dot;
        landmark_report_t report;
        if (kind == KIND_END) begin
            report.found   = (best_sq != NO_LANDMARK_SQ);
            report.dist_sq = best_sq[DSQ_W-1:0];
            report.x       = held_x;
            report.y       = held_y;
            report.z       = held_z;
            report_q.push_back(report);
            best_sq = NO_LANDMARK_SQ;
            return;
        end
        raw_x      = data[42:8];
        raw_y      = data[77:43];
        raw_facing = data[128:113];
        if (data[7:0] != target_type)
            return;
        dx = longint'(raw_x) - pose_x;
        dy = longint'(raw_y) - pose_y;
        // Offsets this large can never be within range; they are dropped before squaring.
        if (dx >= FAR_OFFSET || -dx >= FAR_OFFSET || dy >= FAR_OFFSET || -dy >= FAR_OFFSET)
            return;
        d2 = dx * dx + dy * dy;
        // An equal distance keeps the landmark found first.
        if (d2 >= best_sq || d2 > reach * reach)
            return;
        turn = pose_heading - longint'(raw_facing);
        if (turn > HEADING_SPAN || -turn > HEADING_SPAN)
            return;
        dot = dx * pose_cos + dy * pose_sin;
        if (dot < 0)
            return;
        best_sq = d2;
        held_x  = data[42:8];
        held_y  = data[77:43];
        held_z  = data[112:78];
    endfunction

    always @(posedge aclk) begin
        landmark_report_t got;
        landmark_report_t want;
        if (!aresetn) begin
            pose_x       = 0;
            pose_y       = 0;
            pose_heading = 0;
            pose_cos     = 16384;
            pose_sin     = 0;
            reach        = 10000;
            target_type  = '0;
            best_sq      = NO_LANDMARK_SQ;
            held_x       = '0;
            held_y       = '0;
            held_z       = '0;
            report_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                search_step(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got.found   = m_tuser;
                got.dist_sq = m_tdata[39:0];
                got.x       = m_tdata[74:40];
                got.y       = m_tdata[109:75];
                got.z       = m_tdata[144:110];
                if (report_q.size() == 0) begin
                    miss_count++;
                    if (miss_count <= REPORT_LIMIT)
                        $display("unexpected item: found=%0d dist_sq=%0d x=%0d y=%0d z=%0d",
                                 got.found, got.dist_sq, $signed(got.x), $signed(got.y),
                                 $signed(got.z));
                end else begin
                    want = report_q.pop_front();
                    if (got != want) begin
                        miss_count++;
                        if (miss_count <= REPORT_LIMIT) begin
                            $display("mismatch expected: found=%0d dist_sq=%0d x=%0d y=%0d z=%0d",
                                     want.found, want.dist_sq, $signed(want.x),
                                     $signed(want.y), $signed(want.z));
                            $display("         actual:   found=%0d dist_sq=%0d x=%0d y=%0d z=%0d",
                                     got.found, got.dist_sq, $signed(got.x),
                                     $signed(got.y), $signed(got.z));
                        end
                    end
                end
            end
        end
        owed <= report_q.size();
    end

endmodule

@@ dv/nearest_landmark_ahead_select_tb.sv @@
`timescale 1ns / 1ps
module nearest_landmark_ahead_select_tb;
    import nlas_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     RANDOM_ITEMS = 800;
    localparam longint COORD_TOP    = 64'sd17179869183;
    localparam longint COORD_BOTTOM = -64'sd17179869184;
    localparam longint HEADING_TOP  = 25736;
    localparam longint TRIG_ONE     = 16384;
    localparam longint REACH_TOP    = 999899;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [135:0]       s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [151:0]       m_tdata;
    logic               m_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [COORD_W-1:0] cfg_data;
    int                 owed;
    int                 errors;

    // Both sides run without gaps while this is set.
    bit steady = 1'b0;

    // Pose as programmed, used to aim generated landmarks.
    longint gen_x = 0, gen_y = 0, gen_heading = 0;
    longint gen_cos = TRIG_ONE, gen_sin = 0, gen_reach = 10000;
    logic [TYPE_W-1:0] gen_type = '0;
    longint last_dx = 0, last_dy = 0;

    nearest_landmark_ahead_select i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nearest_landmark_ahead_select_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .owed      (owed),
        .errors    (errors)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint rand35();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'({$urandom, $urandom});
        return longint'(v);
    endfunction

    function automatic longint pick_value(input longint lo, input longint hi,
                                          input longint raw);
        bit [63:0] spin;
        spin = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return lo;
            1: return hi;
            2: return raw;
            default: return lo + longint'(spin % (hi - lo + 1));
        endcase
    endfunction

    function automatic logic [135:0] pack_item(input logic [TYPE_W-1:0] code,
                                               input longint x, input longint y,
                                               input longint z, input longint facing);
        return {7'd0, facing[ANGLE_W-1:0], z[COORD_W-1:0], y[COORD_W-1:0],
                x[COORD_W-1:0], code};
    endfunction

    task automatic send_item(input logic kind, input logic [135:0] data);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds the input until every end item has reported, then lets trailing
    // annotations leave the pipeline.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[COORD_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_pose(input longint x, input longint y, input longint heading,
                                input longint cos_v, input longint sin_v,
                                input longint reach, input logic [TYPE_W-1:0] code,
                                input bit spare);
        if (spare)
            write_reg(REG_SPARE, rand35());
        write_reg(REG_CAR_X, x);
        write_reg(REG_CAR_Y, y);
        write_reg(REG_CAR_HEADING, heading);
        write_reg(REG_HEADING_COS, cos_v);
        write_reg(REG_HEADING_SIN, sin_v);
        write_reg(REG_MAX_DISTANCE, reach);
        write_reg(REG_WANTED_TYPE, longint'(code));
        cfg_valid <= 1'b0;
        gen_x       = x;
        gen_y       = y;
        gen_heading = heading;
        gen_cos     = cos_v;
        gen_sin     = sin_v;
        gen_reach   = reach;
        gen_type    = code;
    endtask

    task automatic send_landmark(input bit tidy);
        longint dx, dy, span, facing;
        logic [TYPE_W-1:0] type_code;
        if (!tidy) begin
            send_item(KIND_ANNOT, pack_item(8'($urandom), rand35(), rand35(), rand35(),
                                            $urandom));
            return;
        end
        span = ($urandom_range(0, 3) == 0) ? gen_reach : gen_reach / 16;
        if ($urandom_range(0, 7) == 0) begin
            // Swapped offsets land at the same distance as the previous landmark.
            dx = last_dy;
            dy = last_dx;
        end else begin
            dx = longint'($urandom_range(0, 32'(2 * span))) - span;
            dy = longint'($urandom_range(0, 32'(2 * span))) - span;
        end
        // Mostly turn points that fall behind the vehicle around to the front.
        if (dx * gen_cos + dy * gen_sin < 0 && $urandom_range(0, 3) != 0) begin
            dx = -dx;
            dy = -dy;
        end
        last_dx = dx;
        last_dy = dy;
        facing = gen_heading + longint'($urandom_range(0, 3200)) - 1600;
        type_code = ($urandom_range(0, 9) == 0) ? 8'($urandom) : gen_type;
        send_item(KIND_ANNOT, pack_item(type_code, gen_x + dx, gen_y + dy, rand35(), facing));
    endtask

    initial begin
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int quota, burst, sent, phase;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset pose: vehicle at the origin facing +x, reach 100 m, type 0.
        send_item(KIND_END, '0);
        send_item(KIND_ANNOT, pack_item(8'd0, 10000, 0, COORD_BOTTOM, 0));
        send_item(KIND_ANNOT, pack_item(8'd0, 10001, 0, 5, 0));
        send_item(KIND_ANNOT, pack_item(8'd0, 3000, 4000, COORD_TOP, 1429));
        send_item(KIND_ANNOT, pack_item(8'd0, 4000, 3000, 7, -1429));
        send_item(KIND_ANNOT, pack_item(8'd0, 0, 0, 8, 1430));
        send_item(KIND_ANNOT, pack_item(8'd0, -1, 0, 9, 0));
        send_item(KIND_ANNOT, pack_item(8'd1, 0, 5, 10, 0));
        send_item(KIND_ANNOT, pack_item(8'd0, 1048576, 0, 11, 0));
        send_item(KIND_ANNOT, pack_item(8'd0, COORD_TOP, COORD_BOTTOM, 12, 25736));
        send_item(KIND_END, pack_item(8'hFF, COORD_TOP, COORD_BOTTOM, COORD_TOP, -1));
        send_item(KIND_END, '0);
        send_item(KIND_ANNOT, pack_item(8'd0, 0, 0, -1, -25736));
        send_item(KIND_ANNOT, pack_item(8'd0, 0, 50, 13, 0));
        send_item(KIND_ANNOT, pack_item(8'd0, 0, 0, -14, 0));
        send_item(KIND_ANNOT, pack_item(8'hFF, 1, 1, 15, 0));
        send_item(KIND_END, '0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            case (phase)
                0: program_pose(COORD_TOP, COORD_BOTTOM, HEADING_TOP, TRIG_ONE, -TRIG_ONE,
                                REACH_TOP, 8'hFF, 1'b1);
                1: program_pose(COORD_BOTTOM, COORD_TOP, -HEADING_TOP, -TRIG_ONE, TRIG_ONE,
                                0, 8'h00, 1'b0);
                2: program_pose(rand35(), rand35(), 0, 32767, -32768, 1048575,
                                8'($urandom), 1'b0);
                default: program_pose(pick_value(COORD_BOTTOM, COORD_TOP, rand35()),
                                      pick_value(COORD_BOTTOM, COORD_TOP, rand35()),
                                      pick_value(-HEADING_TOP, HEADING_TOP, shortint'($urandom)),
                                      pick_value(-TRIG_ONE, TRIG_ONE, shortint'($urandom)),
                                      pick_value(-TRIG_ONE, TRIG_ONE, shortint'($urandom)),
                                      pick_value(0, REACH_TOP, $urandom_range(0, 20000)),
                                      8'($urandom), 1'($urandom_range(0, 1)));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            quota  = $urandom_range(50, 100);
            while (quota > 0) begin
                burst = $urandom_range(0, 10);
                repeat (burst) send_landmark($urandom_range(0, 4) != 0);
                send_item(KIND_END, pack_item(8'($urandom), rand35(), rand35(), rand35(),
                                              $urandom));
                quota -= burst + 1;
                sent  += burst + 1;
            end
            phase++;
        end
        drain_results();

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ nearest_landmark_ahead_select.f @@
+incdir+rtl
rtl/nlas_pkg.sv
rtl/nlas_front.sv
rtl/nlas_queue.sv
rtl/nlas_back.sv
rtl/nearest_landmark_ahead_select.sv
dv/nearest_landmark_ahead_select_checker.sv
dv/nearest_landmark_ahead_select_tb.sv
